### design/fcpmt_pkg.sv
// shared types and constants of the four channel periodic match timer
package fcpmt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_SLOTS     = 4;

    localparam int COUNT_W      = 32;
    localparam int PERIOD_W     = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int ACTION_W     = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hffff;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_CH0     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_CH1     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_CH2     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_CH3     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_IRQ_EN   = 3'd5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                prescale_limit;
        logic [CH_SLOTS-1:0][PERIOD_W-1:0] period;
        logic [CH_SLOTS-1:0]               irq_enable;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic restart;
        logic clear;
    } ch_ctrl_t;

endpackage

### design/fcpmt_cfg_regs.sv
// configuration register file with write decoder
module fcpmt_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fcpmt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fcpmt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fcpmt_pkg::cfg_t                     cfg
);

    fcpmt_pkg::cfg_t cfg_reg;
    fcpmt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fcpmt_pkg::REG_PRESCALE_LIMIT:
                    cfg_next.prescale_limit = cfg_data[fcpmt_pkg::COUNT_W-1:0];
                fcpmt_pkg::REG_PERIOD_CH0:
                    cfg_next.period[0] = cfg_data[fcpmt_pkg::PERIOD_W-1:0];
                fcpmt_pkg::REG_PERIOD_CH1:
                    cfg_next.period[1] = cfg_data[fcpmt_pkg::PERIOD_W-1:0];
                fcpmt_pkg::REG_PERIOD_CH2:
                    cfg_next.period[2] = cfg_data[fcpmt_pkg::PERIOD_W-1:0];
                fcpmt_pkg::REG_PERIOD_CH3:
                    cfg_next.period[3] = cfg_data[fcpmt_pkg::PERIOD_W-1:0];
                fcpmt_pkg::REG_MATCH_IRQ_EN:
                    cfg_next.irq_enable = cfg_data[fcpmt_pkg::CH_SLOTS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_limit <= '0;
            cfg_reg.period         <= {fcpmt_pkg::CH_SLOTS{fcpmt_pkg::PERIOD_RESET}};
            cfg_reg.irq_enable     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/fcpmt_channel.sv
// one match channel: match value, auto advance and sticky flag
module fcpmt_channel
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcpmt_pkg::ch_ctrl_t               ctrl,
    input  logic                              enable,
    input  logic [fcpmt_pkg::PERIOD_W-1:0]    period,
    input  logic [fcpmt_pkg::COUNT_W-1:0]     count_after,
    output logic                              flag_next
);

    logic [fcpmt_pkg::COUNT_W-1:0] match_reg;
    logic [fcpmt_pkg::COUNT_W-1:0] match_next;
    logic                          flag_reg;
    logic                          hit;

    assign hit = ctrl.tick && enable && (match_reg == count_after);

    always_comb
    begin
        match_next = match_reg;
        flag_next  = flag_reg;
        if (ctrl.restart)
        begin
            match_next = {{(fcpmt_pkg::COUNT_W-fcpmt_pkg::PERIOD_W){1'b0}}, period};
            flag_next  = 1'b0;
        end
        else if (hit)
        begin
            match_next = match_reg
                       + {{(fcpmt_pkg::COUNT_W-fcpmt_pkg::PERIOD_W){1'b0}}, period};
            flag_next  = 1'b1;
        end
        else if (ctrl.clear)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

### design/four_channel_periodic_match_timer_unit.sv
// top level: prescaler, counter, match channels and stream stages
// Prescaled 32-bit up-counter with four periodic match channels.
// Input stream s_axis carries one command per beat: tuser holds the action
// (tick, clear flags, restart) and tdata holds the clear mask. Each beat
// produces exactly one result beat on m_axis with the counter value after
// the command, the pending match flags and the irq bit (any flag pending).
// The configuration port writes prescale limit, channel periods and the
// per-channel enables; write it only while no beats are in flight.
// An accepted input beat waits in the input register, then passes through
// the update logic into the result register. One beat is accepted every
// cycle while the receiver does not stall; the rate rests on the
// combinational prescaler compare and the per-channel compare and add.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and s_axis_tready drops until m_axis_tready returns.
// Reset clears the prescaler, counter, match values and flags, sets every
// period to 0xffff and the limit and enables to zero; no beat is pending.
module four_channel_periodic_match_timer_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [fcpmt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fcpmt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fcpmt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // clear_mask[3:0], zero pad
    input  logic [fcpmt_pkg::ACTION_W-1:0]        s_axis_tuser,  // action[1:0]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fcpmt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // count_value[31:0],
                                                                 // match_flags[35:32],
                                                                 // irq[36], zero pad
);

    localparam int CW = fcpmt_pkg::COUNT_W;
    localparam int NS = fcpmt_pkg::CH_SLOTS;

    fcpmt_pkg::cfg_t cfg;

    logic                              in_valid_reg;
    logic [fcpmt_pkg::ACTION_W-1:0]    in_action_reg;
    logic [NS-1:0]                     in_mask_reg;

    logic                              out_valid_reg;
    logic [CW-1:0]                     out_count_reg;
    logic [NS-1:0]                     out_flags_reg;

    logic [CW-1:0]                     prescale_count_reg;
    logic [CW-1:0]                     prescale_count_next;
    logic [CW-1:0]                     timer_count_reg;
    logic [CW-1:0]                     timer_count_next;
    logic [CW-1:0]                     count_after;

    logic                              out_en;
    logic                              step;
    logic                              do_tick;
    logic                              do_clear;
    logic                              do_restart;
    logic                              prescale_wrap;
    logic [NS-1:0]                     flags_next;

    fcpmt_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_en        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_en;
    assign step          = in_valid_reg && out_en;

    always_comb
    begin
        do_tick    = 1'b0;
        do_clear   = 1'b0;
        do_restart = 1'b0;
        unique case (fcpmt_pkg::action_t'(in_action_reg))
            fcpmt_pkg::ACT_TICK:    do_tick    = step;
            fcpmt_pkg::ACT_CLEAR:   do_clear   = step;
            fcpmt_pkg::ACT_RESTART: do_restart = step;
            default:                do_tick    = 1'b0;
        endcase
    end

    assign prescale_wrap = prescale_count_reg >= cfg.prescale_limit;
    assign count_after   = prescale_wrap ? timer_count_reg + 1'b1 : timer_count_reg;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        if (do_restart)
        begin
            prescale_count_next = '0;
            timer_count_next    = '0;
        end
        else if (do_tick)
        begin
            prescale_count_next = prescale_wrap ? '0 : prescale_count_reg + 1'b1;
            timer_count_next    = count_after;
        end
    end

    for (genvar ch = 0; ch < NS; ch++)
    begin : g_ch
        if (ch < fcpmt_pkg::NUM_CHANNELS)
        begin : g_live
            fcpmt_pkg::ch_ctrl_t ctrl;

            assign ctrl.tick    = do_tick;
            assign ctrl.restart = do_restart;
            assign ctrl.clear   = do_clear && in_mask_reg[ch];

            fcpmt_channel u_channel
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .enable      (cfg.irq_enable[ch]),
                .period      (cfg.period[ch]),
                .count_after (count_after),
                .flag_next   (flags_next[ch])
            );
        end
        else
        begin : g_absent
            assign flags_next[ch] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_en)
            begin
                out_valid_reg <= in_valid_reg;
            end
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= s_axis_tuser;
            in_mask_reg   <= s_axis_tdata[NS-1:0];
        end
        if (step)
        begin
            out_count_reg <= timer_count_next;
            out_flags_reg <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fcpmt_pkg::OUT_TDATA_W-CW-NS-1){1'b0}},
                            |out_flags_reg, out_flags_reg, out_count_reg};

    a_irq_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CW+NS] == |m_axis_tdata[CW+NS-1:CW]))
        else $error("irq bit disagrees with match flags");

    a_restart_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        do_restart |=> (timer_count_reg == '0) && (prescale_count_reg == '0))
        else $error("restart left counter or prescaler nonzero");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_tick |=> (timer_count_reg == $past(timer_count_reg))
                 || (timer_count_reg == $past(timer_count_reg) + 1'b1))
        else $error("counter moved by more than one on a tick");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(timer_count_reg) && $stable(prescale_count_reg))
        else $error("counter state changed without a command");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_en |=> in_valid_reg && $stable(in_action_reg))
        else $error("pending command lost during output stall");

endmodule
